### src/hwtf_pkg.sv
// Shared types and constants for the HRV window time-domain feature block.
package hwtf_pkg;

   typedef struct packed {
      logic        cmd;
      logic [11:0] rr_ms;
   } req_type;

   typedef struct packed {
      logic [19:0] window_number;
      logic [31:0] last_beat_time_ms;
      logic [11:0] beat_count;
      logic [22:0] heart_rate_centibpm;
      logic [18:0] rmssd_centims;
      logic [18:0] sdnn_centims;
      logic        overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FL_DIV,
      ST_KEEP_LO,
      ST_KEEP_HI,
      ST_IDX_DIV,
      ST_HR_MUL,
      ST_HR_DIV,
      ST_RM_MUL,
      ST_RM_DIV,
      ST_RM_SQRT,
      ST_SD_NQ,
      ST_SD_SQ,
      ST_SD_NN,
      ST_SD_DIV1,
      ST_SD_MULR,
      ST_SD_DIV2,
      ST_SD_MULQ,
      ST_SD_SQRT,
      ST_EMIT,
      ST_UPD_DIFF,
      ST_UPD_SQ
   } state_type;

   localparam logic        CMD_BEAT  = 1'b0;
   localparam logic        CMD_FLUSH = 1'b1;
   localparam logic        CSR_TOL   = 1'b0;
   localparam logic        CSR_WIN   = 1'b1;

   localparam logic [9:0]  TOL_RESET = 10'd50;
   localparam logic [11:0] WIN_RESET = 12'd120;
   localparam logic [9:0]  MS_PER_S  = 10'd1000;
   localparam logic [10:0] TOL_FULL  = 11'd1000;
   localparam logic [22:0] HR_MAX    = 23'd6000000;
   localparam logic [23:0] HR_SCALE  = 24'd12000000;
   localparam logic [15:0] SD_SCALE  = 16'd40000;

   localparam logic [6:0]  LEN_RR    = 7'd12;
   localparam logic [6:0]  LEN_TLO   = 7'd10;
   localparam logic [6:0]  LEN_THI   = 7'd11;
   localparam logic [6:0]  LEN_TIME  = 7'd32;
   localparam logic [6:0]  LEN_SCALE = 7'd16;
   localparam logic [6:0]  LEN_SQRT  = 7'd32;

endpackage

### src/hwtf_alu.sv
// Shared iterative unit: shift-add multiply, restoring divide, digit-by-digit square root.
module hwtf_alu (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  hwtf_pkg::alu_op_type   op,
   input  logic [63:0]            a,
   input  logic [63:0]            b,
   input  logic [6:0]             len,
   output logic                   done,
   output logic [63:0]            res_q,
   output logic [63:0]            res_r
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [6:0]           cnt_ff, cnt_in;
   hwtf_pkg::alu_op_type op_ff, op_in;
   logic [63:0]          acc_ff, acc_in;
   logic [63:0]          aux_ff, aux_in;
   logic [63:0]          quo_ff, quo_in;
   logic [64:0]          rem_ff, rem_in;
   logic [64:0]          div_sh, div_diff;
   logic [64:0]          sq_sh, sq_trial, sq_diff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      acc_in   = acc_ff;
      aux_in   = aux_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_sh   = {rem_ff[63:0], quo_ff[63]};
      div_diff = div_sh - {1'b0, aux_ff};
      sq_sh    = {rem_ff[62:0], acc_ff[63:62]};
      sq_trial = {1'b0, quo_ff[61:0], 2'b01};
      sq_diff  = sq_sh - sq_trial;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            cnt_in  = len;
            op_in   = op;
            case (op)
               hwtf_pkg::ALU_DIV: begin
                  rem_in = '0;
                  quo_in = a << (7'd64 - len);
                  aux_in = b;
               end
               hwtf_pkg::ALU_SQRT: begin
                  rem_in = '0;
                  quo_in = '0;
                  acc_in = a;
               end
               default: begin
                  acc_in = '0;
                  aux_in = a;
                  quo_in = b;
               end
            endcase
         end
      end else begin
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         case (op_ff)
            hwtf_pkg::ALU_DIV: begin
               if (!div_diff[64]) begin
                  rem_in = div_diff;
                  quo_in = {quo_ff[62:0], 1'b1};
               end else begin
                  rem_in = div_sh;
                  quo_in = {quo_ff[62:0], 1'b0};
               end
            end
            hwtf_pkg::ALU_SQRT: begin
               acc_in = {acc_ff[61:0], 2'b00};
               if (sq_sh >= sq_trial) begin
                  rem_in = sq_diff;
                  quo_in = {quo_ff[62:0], 1'b1};
               end else begin
                  rem_in = sq_sh;
                  quo_in = {quo_ff[62:0], 1'b0};
               end
            end
            default: begin
               if (quo_ff[0]) begin
                  acc_in = acc_ff + aux_ff;
               end
               aux_in = {aux_ff[62:0], 1'b0};
               quo_in = {1'b0, quo_ff[63:1]};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= hwtf_pkg::ALU_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      aux_ff <= aux_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done  = done_ff;
   assign res_q = (op_ff == hwtf_pkg::ALU_MUL) ? acc_ff : quo_ff;
   assign res_r = rem_ff[63:0];

endmodule

### src/hrv_window_time_features.sv
// Top level: beat filter, window tracking and feature sequencer around the shared unit.
//
//   channel | ports                        | direction | moves
//   req     | req_valid/req_ready/req_data | in        | beat or end-of-record command
//   rsp     | rsp_valid/rsp_ready/rsp_data | out       | features of one closed window
//   csr     | csr_we/csr_index/csr_wdata   | in        | tolerance, window length
//
// One item at a time; each step runs the shared unit with its own bit length.
// Synchronous reset clears all record state; csr registers return to 50 and 120.
// A finished window waits in the rsp register; the block stalls only when a second
// window closes before the first is taken.
module hrv_window_time_features #(
   parameter int MAX_WINDOW_BEATS = 4095
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hwtf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hwtf_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [11:0]       csr_wdata
);

   localparam int BEAT_W = $clog2(MAX_WINDOW_BEATS + 1);
   localparam int SUM_W  = 12 + BEAT_W;
   localparam int SQ_W   = 24 + BEAT_W;
   localparam int NN_W   = 2 * BEAT_W;
   localparam logic [6:0] LEN_N   = 7'(BEAT_W);
   localparam logic [6:0] LEN_SUM = 7'(SUM_W);
   localparam logic [6:0] LEN_HR  = 7'(24 + BEAT_W);
   localparam logic [6:0] LEN_RM  = 7'(40 + BEAT_W);
   localparam logic [6:0] LEN_D1  = 7'(24 + 2 * BEAT_W);
   localparam logic [6:0] LEN_D2  = 7'(16 + 2 * BEAT_W);
   localparam logic [BEAT_W-1:0] BEAT_MAX = BEAT_W'(MAX_WINDOW_BEATS);

   hwtf_pkg::state_type state_ff, state_in;
   logic              issued_ff, issued_in;
   logic              flush_ff, flush_in;
   logic [11:0]       rr_ff, rr_in;
   logic [31:0]       t_ff, t_in;
   logic [19:0]       idx_ff, idx_in;
   logic              lo_ok_ff, lo_ok_in;
   logic [63:0]       tmp_ff, tmp_in;
   logic [63:0]       q_ff, q_in;
   logic [NN_W-1:0]   nn_ff, nn_in;
   logic [22:0]       hr_ff, hr_in;
   logic [18:0]       rm_ff, rm_in;
   logic [18:0]       sd_ff, sd_in;

   logic              have_ff, have_in;
   logic [11:0]       prev_ff, prev_in;
   logic [31:0]       elapsed_ff, elapsed_in;
   logic [19:0]       open_ff, open_in;
   logic [BEAT_W-1:0] beats_ff, beats_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [SQ_W-1:0]   dsq_ff, dsq_in;
   logic [11:0]       pwr_ff, pwr_in;
   logic              ovf_ff, ovf_in;
   logic [9:0]        tol_ff, tol_in;
   logic [11:0]       ws_ff, ws_in;

   logic              rsp_valid_ff, rsp_valid_in;
   hwtf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                 alu_start;
   hwtf_pkg::alu_op_type alu_op;
   logic [63:0]          alu_a, alu_b;
   logic [6:0]           alu_len;
   logic                 alu_done;
   logic [63:0]          alu_q, alu_r;

   logic [21:0] wms;
   logic [21:0] lhs;
   logic [11:0] diff;
   logic        clear_win, clear_rec;

   hwtf_alu u_alu (
      .clock (clock),
      .reset (reset),
      .start (alu_start),
      .op    (alu_op),
      .a     (alu_a),
      .b     (alu_b),
      .len   (alu_len),
      .done  (alu_done),
      .res_q (alu_q),
      .res_r (alu_r)
   );

   assign wms  = 22'((ws_ff == 12'd0) ? 12'd1 : ws_ff) * 22'(hwtf_pkg::MS_PER_S);
   assign lhs  = 22'(rr_ff) * 22'(hwtf_pkg::MS_PER_S);
   assign diff = (rr_ff > pwr_ff) ? (rr_ff - pwr_ff) : (pwr_ff - rr_ff);

   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      flush_in     = flush_ff;
      rr_in        = rr_ff;
      t_in         = t_ff;
      idx_in       = idx_ff;
      lo_ok_in     = lo_ok_ff;
      tmp_in       = tmp_ff;
      q_in         = q_ff;
      nn_in        = nn_ff;
      hr_in        = hr_ff;
      rm_in        = rm_ff;
      sd_in        = sd_ff;
      have_in      = have_ff;
      prev_in      = prev_ff;
      elapsed_in   = elapsed_ff;
      open_in      = open_ff;
      beats_in     = beats_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      dsq_in       = dsq_ff;
      pwr_in       = pwr_ff;
      ovf_in       = ovf_ff;
      tol_in       = tol_ff;
      ws_in        = ws_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      alu_start    = 1'b0;
      alu_op       = hwtf_pkg::ALU_MUL;
      alu_a        = '0;
      alu_b        = '0;
      alu_len      = '0;
      clear_win    = 1'b0;
      clear_rec    = 1'b0;
      req_ready    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            hwtf_pkg::CSR_TOL: tol_in = csr_wdata[9:0];
            hwtf_pkg::CSR_WIN: ws_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         hwtf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               flush_in = req_data.cmd;
               rr_in    = req_data.rr_ms;
               t_in     = elapsed_ff + 32'(req_data.rr_ms);
               if (req_data.cmd == hwtf_pkg::CMD_FLUSH) begin
                  if (beats_ff != '0) begin
                     state_in = hwtf_pkg::ST_FL_DIV;
                  end else begin
                     clear_rec = 1'b1;
                  end
               end else if (!have_ff) begin
                  have_in  = 1'b1;
                  prev_in  = req_data.rr_ms;
                  state_in = hwtf_pkg::ST_IDX_DIV;
               end else begin
                  state_in = hwtf_pkg::ST_KEEP_LO;
               end
            end
         end
         hwtf_pkg::ST_FL_DIV: begin
            alu_op  = hwtf_pkg::ALU_DIV;
            alu_a   = 64'(elapsed_ff);
            alu_b   = 64'(wms);
            alu_len = hwtf_pkg::LEN_TIME;
            if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               if ({alu_r[21:0], 1'b0} >= {1'b0, wms}) begin
                  state_in = hwtf_pkg::ST_HR_MUL;
               end else begin
                  clear_rec = 1'b1;
                  state_in  = hwtf_pkg::ST_IDLE;
               end
            end
         end
         hwtf_pkg::ST_KEEP_LO: begin
            alu_op  = hwtf_pkg::ALU_MUL;
            alu_a   = 64'(prev_ff);
            alu_b   = 64'(hwtf_pkg::TOL_FULL - 11'(tol_ff));
            alu_len = hwtf_pkg::LEN_TLO;
            if (11'(tol_ff) > hwtf_pkg::TOL_FULL) begin
               lo_ok_in = 1'b1;
               state_in = hwtf_pkg::ST_KEEP_HI;
            end else if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               lo_ok_in  = (alu_q[21:0] < lhs);
               state_in  = hwtf_pkg::ST_KEEP_HI;
            end
         end
         hwtf_pkg::ST_KEEP_HI: begin
            alu_op  = hwtf_pkg::ALU_MUL;
            alu_a   = 64'(prev_ff);
            alu_b   = 64'(hwtf_pkg::TOL_FULL + 11'(tol_ff));
            alu_len = hwtf_pkg::LEN_THI;
            if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               prev_in   = rr_ff;
               if (lo_ok_ff && ({1'b0, lhs} < alu_q[22:0])) begin
                  state_in = hwtf_pkg::ST_IDX_DIV;
               end else begin
                  state_in = hwtf_pkg::ST_IDLE;
               end
            end
         end
         hwtf_pkg::ST_IDX_DIV: begin
            alu_op  = hwtf_pkg::ALU_DIV;
            alu_a   = 64'(t_ff);
            alu_b   = 64'(wms);
            alu_len = hwtf_pkg::LEN_TIME;
            if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               idx_in    = alu_q[19:0];
               if (beats_ff != '0 && alu_q[19:0] != open_ff) begin
                  state_in = hwtf_pkg::ST_HR_MUL;
               end else begin
                  state_in = hwtf_pkg::ST_UPD_DIFF;
               end
            end
         end
         hwtf_pkg::ST_HR_MUL: begin
            alu_op  = hwtf_pkg::ALU_MUL;
            alu_a   = 64'(hwtf_pkg::HR_SCALE);
            alu_b   = 64'(beats_ff);
            alu_len = LEN_N;
            if (sum_ff == '0) begin
               hr_in    = hwtf_pkg::HR_MAX;
               state_in = hwtf_pkg::ST_RM_MUL;
            end else if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               tmp_in    = alu_q + 64'(sum_ff);
               state_in  = hwtf_pkg::ST_HR_DIV;
            end
         end
         hwtf_pkg::ST_HR_DIV: begin
            alu_op  = hwtf_pkg::ALU_DIV;
            alu_a   = tmp_ff;
            alu_b   = 64'({sum_ff, 1'b0});
            alu_len = LEN_HR;
            if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               hr_in     = (alu_q > 64'(hwtf_pkg::HR_MAX)) ? hwtf_pkg::HR_MAX : alu_q[22:0];
               state_in  = hwtf_pkg::ST_RM_MUL;
            end
         end
         hwtf_pkg::ST_RM_MUL: begin
            alu_op  = hwtf_pkg::ALU_MUL;
            alu_a   = 64'(dsq_ff);
            alu_b   = 64'(hwtf_pkg::SD_SCALE);
            alu_len = hwtf_pkg::LEN_SCALE;
            if (beats_ff <= BEAT_W'(1)) begin
               rm_in    = '0;
               state_in = hwtf_pkg::ST_SD_NQ;
            end else if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               tmp_in    = alu_q;
               state_in  = hwtf_pkg::ST_RM_DIV;
            end
         end
         hwtf_pkg::ST_RM_DIV: begin
            alu_op  = hwtf_pkg::ALU_DIV;
            alu_a   = tmp_ff;
            alu_b   = 64'(beats_ff - BEAT_W'(1));
            alu_len = LEN_RM;
            if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               tmp_in    = alu_q;
               state_in  = hwtf_pkg::ST_RM_SQRT;
            end
         end
         hwtf_pkg::ST_RM_SQRT: begin
            alu_op  = hwtf_pkg::ALU_SQRT;
            alu_a   = tmp_ff;
            alu_len = hwtf_pkg::LEN_SQRT;
            if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               rm_in     = 19'((alu_q[32:0] + 33'd1) >> 1);
               state_in  = hwtf_pkg::ST_SD_NQ;
            end
         end
         hwtf_pkg::ST_SD_NQ: begin
            alu_op  = hwtf_pkg::ALU_MUL;
            alu_a   = 64'(sq_ff);
            alu_b   = 64'(beats_ff);
            alu_len = LEN_N;
            if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               tmp_in    = alu_q;
               state_in  = hwtf_pkg::ST_SD_SQ;
            end
         end
         hwtf_pkg::ST_SD_SQ: begin
            alu_op  = hwtf_pkg::ALU_MUL;
            alu_a   = 64'(sum_ff);
            alu_b   = 64'(sum_ff);
            alu_len = LEN_SUM;
            if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               tmp_in    = (tmp_ff > alu_q) ? (tmp_ff - alu_q) : 64'd0;
               state_in  = hwtf_pkg::ST_SD_NN;
            end
         end
         hwtf_pkg::ST_SD_NN: begin
            alu_op  = hwtf_pkg::ALU_MUL;
            alu_a   = 64'(beats_ff);
            alu_b   = 64'(beats_ff);
            alu_len = LEN_N;
            if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               nn_in     = alu_q[NN_W-1:0];
               state_in  = hwtf_pkg::ST_SD_DIV1;
            end
         end
         hwtf_pkg::ST_SD_DIV1: begin
            alu_op  = hwtf_pkg::ALU_DIV;
            alu_a   = tmp_ff;
            alu_b   = 64'(nn_ff);
            alu_len = LEN_D1;
            if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               q_in      = alu_q;
               tmp_in    = alu_r;
               state_in  = hwtf_pkg::ST_SD_MULR;
            end
         end
         hwtf_pkg::ST_SD_MULR: begin
            alu_op  = hwtf_pkg::ALU_MUL;
            alu_a   = tmp_ff;
            alu_b   = 64'(hwtf_pkg::SD_SCALE);
            alu_len = hwtf_pkg::LEN_SCALE;
            if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               tmp_in    = alu_q;
               state_in  = hwtf_pkg::ST_SD_DIV2;
            end
         end
         hwtf_pkg::ST_SD_DIV2: begin
            alu_op  = hwtf_pkg::ALU_DIV;
            alu_a   = tmp_ff;
            alu_b   = 64'(nn_ff);
            alu_len = LEN_D2;
            if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               tmp_in    = alu_q;
               state_in  = hwtf_pkg::ST_SD_MULQ;
            end
         end
         hwtf_pkg::ST_SD_MULQ: begin
            alu_op  = hwtf_pkg::ALU_MUL;
            alu_a   = q_ff;
            alu_b   = 64'(hwtf_pkg::SD_SCALE);
            alu_len = hwtf_pkg::LEN_SCALE;
            if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               tmp_in    = tmp_ff + alu_q;
               state_in  = hwtf_pkg::ST_SD_SQRT;
            end
         end
         hwtf_pkg::ST_SD_SQRT: begin
            alu_op  = hwtf_pkg::ALU_SQRT;
            alu_a   = tmp_ff;
            alu_len = hwtf_pkg::LEN_SQRT;
            if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               sd_in     = 19'((alu_q[32:0] + 33'd1) >> 1);
               state_in  = hwtf_pkg::ST_EMIT;
            end
         end
         hwtf_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                    = 1'b1;
               rsp_data_in.window_number       = open_ff;
               rsp_data_in.last_beat_time_ms   = elapsed_ff;
               rsp_data_in.beat_count          = 12'(beats_ff);
               rsp_data_in.heart_rate_centibpm = hr_ff;
               rsp_data_in.rmssd_centims       = rm_ff;
               rsp_data_in.sdnn_centims        = sd_ff;
               rsp_data_in.overflow            = ovf_ff;
               if (flush_ff) begin
                  clear_rec = 1'b1;
                  state_in  = hwtf_pkg::ST_IDLE;
               end else begin
                  clear_win = 1'b1;
                  state_in  = hwtf_pkg::ST_UPD_DIFF;
               end
            end
         end
         hwtf_pkg::ST_UPD_DIFF: begin
            alu_op  = hwtf_pkg::ALU_MUL;
            alu_a   = 64'(diff);
            alu_b   = 64'(diff);
            alu_len = hwtf_pkg::LEN_RR;
            if (beats_ff >= BEAT_MAX) begin
               ovf_in     = 1'b1;
               open_in    = idx_ff;
               elapsed_in = t_ff;
               state_in   = hwtf_pkg::ST_IDLE;
            end else if (beats_ff == '0) begin
               state_in = hwtf_pkg::ST_UPD_SQ;
            end else if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               dsq_in    = dsq_ff + alu_q[SQ_W-1:0];
               state_in  = hwtf_pkg::ST_UPD_SQ;
            end
         end
         hwtf_pkg::ST_UPD_SQ: begin
            alu_op  = hwtf_pkg::ALU_MUL;
            alu_a   = 64'(rr_ff);
            alu_b   = 64'(rr_ff);
            alu_len = hwtf_pkg::LEN_RR;
            if (!issued_ff) begin
               alu_start = 1'b1;
               issued_in = 1'b1;
            end else if (alu_done) begin
               issued_in  = 1'b0;
               sq_in      = sq_ff + alu_q[SQ_W-1:0];
               sum_in     = sum_ff + SUM_W'(rr_ff);
               pwr_in     = rr_ff;
               beats_in   = beats_ff + BEAT_W'(1);
               open_in    = idx_ff;
               elapsed_in = t_ff;
               state_in   = hwtf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hwtf_pkg::ST_IDLE;
         end
      endcase

      if (clear_win || clear_rec) begin
         beats_in = '0;
         sum_in   = '0;
         sq_in    = '0;
         dsq_in   = '0;
         pwr_in   = '0;
         ovf_in   = 1'b0;
      end
      if (clear_rec) begin
         have_in    = 1'b0;
         prev_in    = '0;
         elapsed_in = '0;
         open_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hwtf_pkg::ST_IDLE;
         issued_ff    <= 1'b0;
         have_ff      <= 1'b0;
         prev_ff      <= '0;
         elapsed_ff   <= '0;
         open_ff      <= '0;
         beats_ff     <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         dsq_ff       <= '0;
         pwr_ff       <= '0;
         ovf_ff       <= 1'b0;
         tol_ff       <= hwtf_pkg::TOL_RESET;
         ws_ff        <= hwtf_pkg::WIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         have_ff      <= have_in;
         prev_ff      <= prev_in;
         elapsed_ff   <= elapsed_in;
         open_ff      <= open_in;
         beats_ff     <= beats_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         dsq_ff       <= dsq_in;
         pwr_ff       <= pwr_in;
         ovf_ff       <= ovf_in;
         tol_ff       <= tol_in;
         ws_ff        <= ws_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flush_ff    <= flush_in;
      rr_ff       <= rr_in;
      t_ff        <= t_in;
      idx_ff      <= idx_in;
      lo_ok_ff    <= lo_ok_in;
      tmp_ff      <= tmp_in;
      q_ff        <= q_in;
      nn_ff       <= nn_in;
      hr_ff       <= hr_in;
      rm_ff       <= rm_in;
      sd_ff       <= sd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### tb/tb_hrv_window_time_features.sv
// Self-checking testbench for the HRV window time-domain feature block.
module tb_hrv_window_time_features;

   typedef struct {
      logic              cmd;
      logic [11:0]       rr;
      bit                typed;
      hwtf_pkg::rsp_type feat;
   } beat_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   hwtf_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   hwtf_pkg::rsp_type rsp_data;
   logic              csr_we = 1'b0;
   logic              csr_index = hwtf_pkg::CSR_TOL;
   logic [11:0]       csr_wdata = '0;

   hwtf_pkg::rsp_type expected_windows[$];
   int                errors = 0;
   int                ready_hold = 0;

   // shadow copy of the block's registers and record state
   logic [9:0]      tol_pm;
   logic [11:0]     win_s;
   bit              first_seen;
   logic [11:0]     last_raw_rr;
   logic [31:0]     run_ms;
   logic [19:0]     cur_window;
   int unsigned     n_beats;
   longint unsigned sum_rr, sum_rr_sq, sum_diff_sq;
   logic [11:0]     last_kept_rr;
   bit              dropped;

   hrv_window_time_features u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #50000000;
      $display("FAIL hrv_window_time_features");
      $finish;
   end

   function automatic longint unsigned half_round_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return (res + 1) / 2;
   endfunction

   function automatic longint unsigned window_len_ms();
      return (win_s == 0 ? 64'd1 : 64'(win_s)) * 1000;
   endfunction

   function automatic hwtf_pkg::rsp_type window_features();
      hwtf_pkg::rsp_type f;
      longint unsigned   n, hr, rm, sd, sq, nq, v, nn, q, r;
      n = n_beats;
      if (sum_rr == 0) hr = 6000000;
      else hr = (64'd12000000 * n + sum_rr) / (2 * sum_rr);
      if (hr > 6000000) hr = 6000000;
      rm = 0;
      if (n > 1) rm = half_round_sqrt((64'd40000 * sum_diff_sq) / (n - 1));
      sq = sum_rr * sum_rr;
      nq = n * sum_rr_sq;
      v = nq > sq ? nq - sq : 0;
      nn = n * n;
      q = v / nn;
      r = v % nn;
      sd = half_round_sqrt(64'd40000 * q + (64'd40000 * r) / nn);
      f.window_number       = cur_window;
      f.last_beat_time_ms   = run_ms;
      f.beat_count          = n[11:0];
      f.heart_rate_centibpm = hr[22:0];
      f.rmssd_centims       = rm[18:0];
      f.sdnn_centims        = sd[18:0];
      f.overflow            = dropped;
      return f;
   endfunction

   task automatic clear_record_window();
      n_beats = 0;
      sum_rr = 0;
      sum_rr_sq = 0;
      sum_diff_sq = 0;
      last_kept_rr = 0;
      dropped = 0;
   endtask

   task automatic clear_record();
      first_seen = 0;
      last_raw_rr = 0;
      run_ms = 0;
      cur_window = 0;
      clear_record_window();
   endtask

   task automatic predict_window(input hwtf_pkg::req_type it, output bit closed,
                                 output hwtf_pkg::rsp_type f);
      bit              keep;
      longint          lhs, lo, hi;
      logic [31:0]     t;
      longint unsigned d;
      logic [19:0]     idx;
      closed = 0;
      f = '0;
      if (it.cmd == hwtf_pkg::CMD_FLUSH) begin
         if (n_beats > 0 && 2 * (64'(run_ms) % window_len_ms()) >= window_len_ms()) begin
            f = window_features();
            closed = 1;
         end
         clear_record();
         return;
      end
      if (!first_seen) begin
         keep = 1;
         first_seen = 1;
      end else begin
         lhs = longint'(it.rr_ms) * 1000;
         lo = longint'(last_raw_rr) * (1000 - longint'(tol_pm));
         hi = longint'(last_raw_rr) * (1000 + longint'(tol_pm));
         keep = lhs > lo && lhs < hi;
      end
      last_raw_rr = it.rr_ms;
      if (!keep) return;
      t = run_ms + it.rr_ms;
      idx = 20'(64'(t) / window_len_ms());
      if (n_beats > 0 && idx != cur_window) begin
         f = window_features();
         closed = 1;
         clear_record_window();
      end
      cur_window = idx;
      if (n_beats < 4095) begin
         if (n_beats > 0) begin
            d = it.rr_ms > last_kept_rr ? it.rr_ms - last_kept_rr : last_kept_rr - it.rr_ms;
            sum_diff_sq += d * d;
         end
         sum_rr += it.rr_ms;
         sum_rr_sq += longint'(it.rr_ms) * it.rr_ms;
         last_kept_rr = it.rr_ms;
         n_beats++;
      end else begin
         dropped = 1;
      end
      run_ms = t;
   endtask

   task automatic pick_gap(output int g);
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) g = 0;
      else if (p < 95) g = $urandom_range(1, 4);
      else g = $urandom_range(10, 60);
   endtask

   task automatic send_item(input hwtf_pkg::req_type it, input int g, input bit typed,
                            input hwtf_pkg::rsp_type feat);
      bit                closed;
      hwtf_pkg::rsp_type f;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      predict_window(it, closed, f);
      if (closed) expected_windows = {expected_windows, (typed ? feat : f)};
   endtask

   task automatic send_random_gap(input hwtf_pkg::req_type it);
      int g;
      pick_gap(g);
      send_item(it, g, 0, '0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_windows.size() > 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [11:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == hwtf_pkg::CSR_TOL) tol_pm = val[9:0];
      else win_s = val;
   endtask

   task automatic report_field(input string name, input longint unsigned e,
                               input longint unsigned a);
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
      errors++;
   endtask

   task automatic check_window(input hwtf_pkg::rsp_type got);
      hwtf_pkg::rsp_type e;
      if (expected_windows.size() == 0) begin
         $display("%0t unexpected transfer: expected none actual %p", $time, got);
         errors++;
         return;
      end
      e = expected_windows.pop_front();
      if (got.window_number !== e.window_number)
         report_field("window_number", e.window_number, got.window_number);
      if (got.last_beat_time_ms !== e.last_beat_time_ms)
         report_field("last_beat_time_ms", e.last_beat_time_ms, got.last_beat_time_ms);
      if (got.beat_count !== e.beat_count)
         report_field("beat_count", e.beat_count, got.beat_count);
      if (got.heart_rate_centibpm !== e.heart_rate_centibpm)
         report_field("heart_rate_centibpm", e.heart_rate_centibpm, got.heart_rate_centibpm);
      if (got.rmssd_centims !== e.rmssd_centims)
         report_field("rmssd_centims", e.rmssd_centims, got.rmssd_centims);
      if (got.sdnn_centims !== e.sdnn_centims)
         report_field("sdnn_centims", e.sdnn_centims, got.sdnn_centims);
      if (got.overflow !== e.overflow)
         report_field("overflow", e.overflow, got.overflow);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            check_window(rsp_data);
         end
         if (ready_hold > 0) begin
            ready_hold--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 99) < 20) begin
            ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      beat_row_type      rows[22];
      hwtf_pkg::req_type it;
      logic [11:0]       next_rr;
      logic [9:0]        tol_set[8];
      logic [11:0]       win_set[8];

      tol_pm = hwtf_pkg::TOL_RESET;
      win_s = hwtf_pkg::WIN_RESET;
      clear_record();

      rows = '{
         '{hwtf_pkg::CMD_BEAT,  12'd1000, 1'b0, '0},
         '{hwtf_pkg::CMD_BEAT,  12'd1000, 1'b1,
           '{20'd1, 32'd1000, 12'd1, 23'd6000, 19'd0, 19'd0, 1'b0}},
         '{hwtf_pkg::CMD_BEAT,  12'd1049, 1'b0, '0},
         '{hwtf_pkg::CMD_BEAT,  12'd1100, 1'b0, '0},
         '{hwtf_pkg::CMD_BEAT,  12'd4095, 1'b0, '0},
         '{hwtf_pkg::CMD_BEAT,  12'd0,    1'b0, '0},
         '{hwtf_pkg::CMD_BEAT,  12'd4095, 1'b0, '0},
         '{hwtf_pkg::CMD_BEAT,  12'd4000, 1'b0, '0},
         '{hwtf_pkg::CMD_BEAT,  12'd3900, 1'b0, '0},
         '{hwtf_pkg::CMD_BEAT,  12'd600,  1'b0, '0},
         '{hwtf_pkg::CMD_FLUSH, 12'd4095, 1'b0, '0},
         '{hwtf_pkg::CMD_FLUSH, 12'd0,    1'b0, '0},
         '{hwtf_pkg::CMD_BEAT,  12'd0,    1'b0, '0},
         '{hwtf_pkg::CMD_BEAT,  12'd0,    1'b0, '0},
         '{hwtf_pkg::CMD_FLUSH, 12'd0,    1'b0, '0},
         '{hwtf_pkg::CMD_BEAT,  12'd1,    1'b0, '0},
         '{hwtf_pkg::CMD_BEAT,  12'd1,    1'b0, '0},
         '{hwtf_pkg::CMD_BEAT,  12'd700,  1'b0, '0},
         '{hwtf_pkg::CMD_BEAT,  12'd720,  1'b0, '0},
         '{hwtf_pkg::CMD_BEAT,  12'd1000, 1'b0, '0},
         '{hwtf_pkg::CMD_BEAT,  12'd2730, 1'b0, '0},
         '{hwtf_pkg::CMD_FLUSH, 12'd0,    1'b0, '0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_csr(hwtf_pkg::CSR_WIN, 12'd1);
      foreach (rows[i]) begin
         it.cmd = rows[i].cmd;
         it.rr_ms = rows[i].rr;
         send_item(it, (i % 3 == 2) ? 2 : 0, rows[i].typed, rows[i].feat);
      end
      drain();

      tol_set = '{10'd50, 10'd1000, 10'd0, 10'd1023, 10'd200, 10'd100, 10'd500, 10'd80};
      win_set = '{12'd2, 12'd1, 12'd3, 12'd0, 12'd10, 12'd4095, 12'd5, 12'd120};
      next_rr = 12'd800;
      for (int p = 0; p < 8; p++) begin
         write_csr(hwtf_pkg::CSR_TOL, {2'b00, tol_set[p]});
         write_csr(hwtf_pkg::CSR_WIN, win_set[p]);
         repeat (90) begin
            case ($urandom_range(0, 19))
               0: it.cmd = hwtf_pkg::CMD_FLUSH;
               default: it.cmd = hwtf_pkg::CMD_BEAT;
            endcase
            case ($urandom_range(0, 9))
               0: next_rr = 12'($urandom_range(0, 4095));
               1: next_rr = ($urandom_range(0, 1) == 1) ? 12'd4095 : 12'd1;
               default: begin
                  next_rr = next_rr + 12'($urandom_range(0, 60)) - 12'd30;
                  if (next_rr < 250 || next_rr > 2500) next_rr = 12'($urandom_range(400, 1500));
               end
            endcase
            it.rr_ms = (it.cmd == hwtf_pkg::CMD_FLUSH) ? 12'($urandom_range(0, 4095)) : next_rr;
            send_random_gap(it);
         end
         it.cmd = hwtf_pkg::CMD_FLUSH;
         send_random_gap(it);
         drain();
      end

      if (errors == 0)
         $display("PASS hrv_window_time_features");
      else
         $display("FAIL hrv_window_time_features");
      $finish;
   end

endmodule
